// File: rtl/sbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_pkg
// types and constants shared by the bytecode machine modules
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int unsigned PC_W      = 17;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned STATUS_W  = 4;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned OP_W      = 8;
  localparam int unsigned INSN_LONG = 5;
  localparam int unsigned IMM_BYTES = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 8'd0,
    OP_HALT  = 8'd1,
    OP_POP   = 8'd2,
    OP_DUP   = 8'd3,
    OP_ADD   = 8'd4,
    OP_SUB   = 8'd5,
    OP_MUL   = 8'd6,
    OP_DIV   = 8'd7,
    OP_CMP   = 8'd8,
    OP_JMP   = 8'd9,
    OP_JZ    = 8'd10,
    OP_JNZ   = 8'd11,
    OP_STM   = 8'd12,
    OP_LOAD  = 8'd13,
    OP_CALL  = 8'd14,
    OP_RET   = 8'd15
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN       = 4'd0,
    ST_HALT      = 4'd1,
    ST_PC_BOUNDS = 4'd2,
    ST_SHORT     = 4'd3,
    ST_OVF       = 4'd4,
    ST_UNF       = 4'd5,
    ST_DIV0      = 4'd6,
    ST_TARGET    = 4'd7,
    ST_INDEX     = 4'd8,
    ST_RET_OVF   = 4'd9,
    ST_RET_UNF   = 4'd10,
    ST_BAD_OP    = 4'd11
  } status_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_LT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

endpackage
`default_nettype wire

// File: rtl/stack_bytecode_machine_step_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_bytecode_machine_step_top
// one bytecode instruction per item against data stack, return stack and
// word memory
// ----------------------------------------------------------------------------
// usage: the fetcher offers opcode and operand on the in_ channel; one result
// item (next_pc, status, top_value, stack_depth) follows on the out_ channel.
// cfg_ writes program_length; the user must write it only while the block is
// idle; the block itself does not enforce it. mul and div run 32 steps of
// the shared alu. the stack and memory ports have one read and one write
// each, with registered read.
// one item at a time: in_stall is high from accept until the cycle after the
// result is taken.
// reset: pc, depths and status clear; a clearing pass over all MEMORY_WORDS
// words zeroes word memory, with in_stall high throughout.
// a stalled out_ channel holds its result; the next item waits behind it.
// ----------------------------------------------------------------------------
module stack_bytecode_machine_step_top #(
  parameter int unsigned DATA_STACK_DEPTH   = 256,
  parameter int unsigned RETURN_STACK_DEPTH = 64,
  parameter int unsigned MEMORY_WORDS       = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_opcode,
  input  wire logic [31:0] in_operand,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      out_next_pc,
  output logic [3:0]       out_status,
  output logic [31:0]      out_top_value,
  output logic [8:0]       out_stack_depth,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import sbm_pkg::*;

  localparam int unsigned DA_W = (DATA_STACK_DEPTH > 1) ? $clog2(DATA_STACK_DEPTH) : 1;
  localparam int unsigned DD_W = $clog2(DATA_STACK_DEPTH + 1);
  localparam int unsigned RA_W = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
  localparam int unsigned RD_W = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int unsigned MA_W = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
  localparam int unsigned MC_W = $clog2(MEMORY_WORDS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_ALU, S_MEMRD, S_FIN, S_TOP, S_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [LEN_W-1:0]       plen_r;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic [DD_W-1:0]        dd_r, dd_nxt;
  logic [RD_W-1:0]        rd_r, rd_nxt;
  logic [STATUS_W-1:0]    st_r, st_nxt;
  logic [OP_W-1:0]        op_r;
  logic [WORD_W-1:0]      imm_r;
  logic [WORD_W-1:0]      b_r, b_nxt;
  logic [MC_W-1:0]        clr_r, clr_nxt;

  logic [WORD_W-1:0]      dmem [DATA_STACK_DEPTH];
  logic [PC_W-1:0]        rmem [RETURN_STACK_DEPTH];
  logic [WORD_W-1:0]      wmem [MEMORY_WORDS];

  logic                   d_re;
  logic [DA_W-1:0]        d_ra;
  logic [WORD_W-1:0]      d_rdata;
  logic                   d_we;
  logic [DA_W-1:0]        d_wa;
  logic [WORD_W-1:0]      d_wd;
  logic [PC_W-1:0]        r_rdata;
  logic                   r_we;
  logic [PC_W-1:0]        r_wd;
  logic                   m_re;
  logic [WORD_W-1:0]      m_rdata;
  logic                   m_we;
  logic [MA_W-1:0]        m_wa;
  logic [WORD_W-1:0]      m_wd;

  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;
  logic [WORD_W-1:0]      alu_res;
  logic                   ov_r, ov_nxt;
  logic [PC_W-1:0]        o_pc_r, o_pc_nxt;
  logic [STATUS_W-1:0]    o_st_r, o_st_nxt;
  logic [WORD_W-1:0]      o_top_r, o_top_nxt;
  logic [8:0]             o_dd_r, o_dd_nxt;

  logic                   has_imm;
  logic                   imm_tgt_ok;
  logic                   imm_idx_ok;
  logic                   full;
  logic [PC_W-1:0]        pc_p1, pc_p5;

  // second operand read lands in d_rdata during S_EXEC
  sbm_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (d_rdata),
    .b      (b_r),
    .rsp    (alu_rsp),
    .result (alu_res)
  );

  assign has_imm = (op_r == OP_PUSH) || (op_r == OP_JMP) || (op_r == OP_JZ) ||
                   (op_r == OP_JNZ) || (op_r == OP_STM) || (op_r == OP_LOAD) ||
                   (op_r == OP_CALL);
  assign imm_tgt_ok = (imm_r[WORD_W-1:LEN_W] == '0) && (imm_r[LEN_W-1:0] < plen_r);
  assign imm_idx_ok = (imm_r < WORD_W'(MEMORY_WORDS));
  assign full  = (dd_r >= DD_W'(DATA_STACK_DEPTH));
  assign pc_p1 = pc_r + PC_W'(1);
  assign pc_p5 = pc_r + PC_W'(INSN_LONG);

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_next_pc     = o_pc_r;
  assign out_status      = o_st_r;
  assign out_top_value   = o_top_r;
  assign out_stack_depth = o_dd_r;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    dd_nxt    = dd_r;
    rd_nxt    = rd_r;
    st_nxt    = st_r;
    b_nxt     = b_r;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r;
    o_pc_nxt  = o_pc_r;
    o_st_nxt  = o_st_r;
    o_top_nxt = o_top_r;
    o_dd_nxt  = o_dd_r;
    d_re = 1'b0;
    d_ra = '0;
    d_we = 1'b0;
    d_wa = '0;
    d_wd = '0;
    r_we = 1'b0;
    r_wd = pc_p5;
    m_re = 1'b0;
    m_we = 1'b0;
    m_wa = '0;
    m_wd = '0;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_ADD;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        m_we = 1'b1;
        m_wa = clr_r[MA_W-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == MC_W'(MEMORY_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        d_re = (dd_r != '0);
        d_ra = DA_W'(dd_r - 1'b1);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        b_nxt = d_rdata;
        d_re = (dd_r > DD_W'(1));
        d_ra = DA_W'(dd_r - DD_W'(2));
        m_re = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_TOP;
        if (st_r != ST_RUN) begin
          state_nxt = S_TOP;
        end else if (pc_r >= {1'b0, plen_r}) begin
          st_nxt = ST_PC_BOUNDS;
        end else if (has_imm && (pc_r + PC_W'(IMM_BYTES) >= {1'b0, plen_r})) begin
          st_nxt = ST_SHORT;
        end else begin
          case (op_r)
            OP_PUSH: begin
              if (full) st_nxt = ST_OVF;
              else begin
                d_we = 1'b1; d_wa = DA_W'(dd_r); d_wd = imm_r;
                dd_nxt = dd_r + 1'b1; pc_nxt = pc_p5;
              end
            end
            OP_HALT: begin
              st_nxt = ST_HALT; pc_nxt = pc_p1;
            end
            OP_POP: begin
              if (dd_r == '0) st_nxt = ST_UNF;
              else begin
                dd_nxt = dd_r - 1'b1; pc_nxt = pc_p1;
              end
            end
            OP_DUP: begin
              if (dd_r == '0) st_nxt = ST_UNF;
              else if (full) st_nxt = ST_OVF;
              else begin
                d_we = 1'b1; d_wa = DA_W'(dd_r); d_wd = b_r;
                dd_nxt = dd_r + 1'b1; pc_nxt = pc_p1;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
              if (dd_r < DD_W'(2)) st_nxt = ST_UNF;
              else begin
                dd_nxt = dd_r - DD_W'(2);
                if (op_r == OP_DIV && b_r == '0) st_nxt = ST_DIV0;
                else begin
                  state_nxt = S_ALU;
                  alu_req.start = 1'b1;
                  case (op_r)
                    OP_ADD:  alu_req.op = ALU_ADD;
                    OP_SUB:  alu_req.op = ALU_SUB;
                    OP_MUL:  alu_req.op = ALU_MUL;
                    OP_DIV:  alu_req.op = ALU_DIV;
                    default: alu_req.op = ALU_LT;
                  endcase
                end
              end
            end
            OP_JMP: begin
              if (!imm_tgt_ok) st_nxt = ST_TARGET;
              else pc_nxt = imm_r[PC_W-1:0];
            end
            OP_JZ, OP_JNZ: begin
              if (dd_r == '0) st_nxt = ST_UNF;
              else begin
                dd_nxt = dd_r - 1'b1;
                if ((op_r == OP_JZ) == (b_r == '0)) begin
                  if (!imm_tgt_ok) st_nxt = ST_TARGET;
                  else pc_nxt = imm_r[PC_W-1:0];
                end else pc_nxt = pc_p5;
              end
            end
            OP_STM: begin
              if (dd_r == '0) st_nxt = ST_UNF;
              else if (!imm_idx_ok) st_nxt = ST_INDEX;
              else begin
                m_we = 1'b1; m_wa = imm_r[MA_W-1:0]; m_wd = b_r;
                dd_nxt = dd_r - 1'b1; pc_nxt = pc_p5;
              end
            end
            OP_LOAD: begin
              if (full) st_nxt = ST_OVF;
              else if (!imm_idx_ok) st_nxt = ST_INDEX;
              else state_nxt = S_MEMRD;
            end
            OP_CALL: begin
              if (rd_r >= RD_W'(RETURN_STACK_DEPTH)) st_nxt = ST_RET_OVF;
              else if (!imm_tgt_ok) st_nxt = ST_TARGET;
              else begin
                r_we = 1'b1; rd_nxt = rd_r + 1'b1; pc_nxt = imm_r[PC_W-1:0];
              end
            end
            OP_RET: begin
              if (rd_r == '0) st_nxt = ST_RET_UNF;
              else begin
                rd_nxt = rd_r - 1'b1; pc_nxt = r_rdata;
              end
            end
            default: st_nxt = ST_BAD_OP;
          endcase
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          d_we = 1'b1; d_wa = DA_W'(dd_r); d_wd = alu_res;
          dd_nxt = dd_r + 1'b1; pc_nxt = pc_p1;
          state_nxt = S_TOP;
        end
      end
      S_MEMRD: begin
        d_we = 1'b1; d_wa = DA_W'(dd_r); d_wd = m_rdata;
        dd_nxt = dd_r + 1'b1; pc_nxt = pc_p5;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        d_re = (dd_r != '0);
        d_ra = DA_W'(dd_r - 1'b1);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          o_pc_nxt  = pc_r;
          o_st_nxt  = st_r;
          o_top_nxt = (dd_r != '0) ? d_rdata : '0;
          o_dd_nxt  = 9'(dd_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      plen_r  <= 16'hFFFF;
      pc_r    <= '0;
      dd_r    <= '0;
      rd_r    <= '0;
      st_r    <= ST_RUN;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) plen_r <= cfg_data;
      pc_r    <= pc_nxt;
      dd_r    <= dd_nxt;
      rd_r    <= rd_nxt;
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      op_r  <= in_opcode;
      imm_r <= in_operand;
    end
    b_r     <= b_nxt;
    o_pc_r  <= o_pc_nxt;
    o_st_r  <= o_st_nxt;
    o_top_r <= o_top_nxt;
    o_dd_r  <= o_dd_nxt;
  end

  // data stack: one read, one write port
  always_ff @(posedge clk) begin
    if (d_we) dmem[d_wa] <= d_wd;
    if (d_re) d_rdata <= dmem[d_ra];
  end

  // return stack
  always_ff @(posedge clk) begin
    if (r_we) rmem[RA_W'(rd_r)] <= r_wd;
    r_rdata <= rmem[RA_W'(rd_r - 1'b1)];
  end

  // word memory
  always_ff @(posedge clk) begin
    if (m_we) wmem[m_wa] <= m_wd;
    if (m_re) m_rdata <= wmem[imm_r[MA_W-1:0]];
  end

`ifndef SYNTHESIS
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    dd_r <= DD_W'(DATA_STACK_DEPTH)) else $error("data depth over limit");
  a_ret_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_r <= RD_W'(RETURN_STACK_DEPTH)) else $error("return depth over limit");
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_RUN) |=> (st_r == $past(st_r))) else $error("stop status changed");
  a_pc_frozen_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_RUN) |=> $stable(pc_r)) else $error("pc moved while stopped");
`endif

endmodule
`default_nettype wire

// File: rtl/sbm_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_alu
// shared arithmetic unit: add, sub and compare with a registered result,
// shift-add multiply and restoring divide, one bit per cycle
// ----------------------------------------------------------------------------
module sbm_alu (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sbm_pkg::alu_req_t          req,
  input  wire logic [sbm_pkg::WORD_W-1:0] a,
  input  wire logic [sbm_pkg::WORD_W-1:0] b,
  output sbm_pkg::alu_rsp_t               rsp,
  output logic [sbm_pkg::WORD_W-1:0]      result
);
  import sbm_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W) + 1;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  alu_op_t             op_r, op_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [WORD_W-1:0]   acc_r, acc_nxt;
  logic [WORD_W-1:0]   sa_r, sa_nxt;
  logic [WORD_W-1:0]   sb_r, sb_nxt;
  logic [WORD_W-1:0]   rem_r, rem_nxt;
  logic                neg_r, neg_nxt;
  logic [WORD_W-1:0]   abs_a, abs_b;
  logic [WORD_W:0]     trial;
  logic [WORD_W:0]     rem_sh;

  assign abs_a  = a[WORD_W-1] ? (~a + 1'b1) : a;
  assign abs_b  = b[WORD_W-1] ? (~b + 1'b1) : b;
  assign rem_sh = {rem_r, sa_r[WORD_W-1]};
  assign trial  = rem_sh - {1'b0, sb_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sa_nxt   = sa_r;
    sb_nxt   = sb_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      op_nxt = req.op;
      unique case (req.op)
        ALU_ADD: begin
          acc_nxt  = a + b;
          done_nxt = 1'b1;
        end
        ALU_SUB: begin
          acc_nxt  = a - b;
          done_nxt = 1'b1;
        end
        ALU_LT: begin
          acc_nxt  = {{(WORD_W-1){1'b0}}, ($signed(a) < $signed(b))};
          done_nxt = 1'b1;
        end
        ALU_MUL: begin
          acc_nxt  = '0;
          sa_nxt   = a;
          sb_nxt   = b;
          cnt_nxt  = CNT_W'(WORD_W);
          busy_nxt = 1'b1;
        end
        ALU_DIV: begin
          acc_nxt  = '0;
          sa_nxt   = abs_a;
          sb_nxt   = abs_b;
          rem_nxt  = '0;
          neg_nxt  = a[WORD_W-1] ^ b[WORD_W-1];
          cnt_nxt  = CNT_W'(WORD_W);
          busy_nxt = 1'b1;
        end
        default: begin
          acc_nxt  = '0;
          done_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        if (sb_r[0]) acc_nxt = acc_r + sa_r;
        sa_nxt = {sa_r[WORD_W-2:0], 1'b0};
        sb_nxt = {1'b0, sb_r[WORD_W-1:1]};
      end else begin
        if (!trial[WORD_W]) begin
          rem_nxt = trial[WORD_W-1:0];
          acc_nxt = {acc_r[WORD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[WORD_W-1:0];
          acc_nxt = {acc_r[WORD_W-2:0], 1'b0};
        end
        sa_nxt = {sa_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    sa_r  <= sa_nxt;
    sb_r  <= sb_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign result   = (op_r == ALU_DIV && neg_r) ? (~acc_r + 1'b1) : acc_r;

endmodule
`default_nettype wire
